// ----- sv/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared constants, operation codes and the control word that travels along
// the divider chain.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int CAU_WIDTH     = 16;
   localparam int CAU_FRAC_BITS = 8;
   localparam int CAU_CMD_W     = 3;

   localparam logic [CAU_CMD_W-1:0] CMD_ADD = 3'd0;
   localparam logic [CAU_CMD_W-1:0] CMD_SUB = 3'd1;
   localparam logic [CAU_CMD_W-1:0] CMD_MUL = 3'd2;
   localparam logic [CAU_CMD_W-1:0] CMD_DIV = 3'd3;
   localparam logic [CAU_CMD_W-1:0] CMD_EQ  = 3'd4;

   typedef struct packed {
      logic valid;
      logic is_div;
      logic dz;
      logic eq;
      logic sat;
      logic neg_re;
      logic neg_im;
      logic ovf_re;
      logic ovf_im;
   } cau_ctl_type;

endpackage

// ----- sv/cau_req_if.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit request channel
// Valid/ready channel carrying the command and both complex operands.
// ----------------------------------------------------------------------------
interface cau_req_if #(
   parameter int WIDTH = cau_pkg::CAU_WIDTH
);
   import cau_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CAU_CMD_W-1:0]    cmd;
   logic signed [WIDTH-1:0] a_re;
   logic signed [WIDTH-1:0] a_im;
   logic signed [WIDTH-1:0] b_re;
   logic signed [WIDTH-1:0] b_im;

   modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

// ----- sv/cau_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit response channel
// Valid/ready channel carrying the complex result and its status flags.
// ----------------------------------------------------------------------------
interface cau_rsp_if #(
   parameter int WIDTH = cau_pkg::CAU_WIDTH
);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] res_re;
   logic signed [WIDTH-1:0] res_im;
   logic                    is_equal;
   logic                    div_by_zero;
   logic                    saturated;

   modport source (output valid, res_re, res_im, is_equal, div_by_zero, saturated,
                   input ready);
   modport sink   (input valid, res_re, res_im, is_equal, div_by_zero, saturated,
                   output ready);
endinterface

// ----- sv/complex_arith_unit.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide and compare of two signed fixed-point
// complex numbers, fully pipelined.
// ----------------------------------------------------------------------------
// Requests arrive on req_if (command and operands a, b) and responses leave
// on rsp_if (result, equality, divide-by-zero and saturation flags), both
// valid/ready channels. Exactly one response is produced per request, in
// order.
// A response passes three front-end stages, one divider cell per quotient
// bit (WIDTH + 1 cells) and the output register. Every operation takes the
// same path, so responses never overtake each other.
// Throughput is one request per cycle unless stalled; the chain sets latency.
// When the receiver stalls, the whole pipeline holds and req_if.ready drops
// only while the output register holds a response that is not taken.
// Reset clears the valid bits and control words; data is not reset.
// ----------------------------------------------------------------------------
module complex_arith_unit #(
   parameter int WIDTH     = cau_pkg::CAU_WIDTH,
   parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_if,
   cau_rsp_if.source rsp_if
);
   import cau_pkg::*;

   localparam int DW = 2 * WIDTH;
   localparam int QB = WIDTH + 1;
   localparam logic [WIDTH-1:0] MAXV  = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic [WIDTH-1:0] MINV  = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [QB-1:0]    MAXQ  = {2'b00, {(WIDTH-1){1'b1}}};
   localparam logic [QB-1:0]    MINQ  = {2'b01, {(WIDTH-1){1'b0}}};

   logic adv;
   logic out_valid_ff;

   assign adv          = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = adv;

   cau_ctl_type      ctl_s     [0:QB];
   logic [WIDTH-1:0] side_re_s [0:QB];
   logic [WIDTH-1:0] side_im_s [0:QB];
   logic [DW-1:0]    den_s     [0:QB];
   logic [DW-1:0]    rem_re_s  [0:QB];
   logic [DW-1:0]    rem_im_s  [0:QB];
   logic [QB-1:0]    nl_re_s   [0:QB];
   logic [QB-1:0]    nl_im_s   [0:QB];
   logic [QB-1:0]    q_re_s    [0:QB];
   logic [QB-1:0]    q_im_s    [0:QB];

   cau_front #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_i   (req_if.valid),
      .cmd_i     (req_if.cmd),
      .a_re_i    (req_if.a_re),
      .a_im_i    (req_if.a_im),
      .b_re_i    (req_if.b_re),
      .b_im_i    (req_if.b_im),
      .ctl_o     (ctl_s[0]),
      .side_re_o (side_re_s[0]),
      .side_im_o (side_im_s[0]),
      .den_o     (den_s[0]),
      .rem_re_o  (rem_re_s[0]),
      .rem_im_o  (rem_im_s[0]),
      .nl_re_o   (nl_re_s[0]),
      .nl_im_o   (nl_im_s[0])
   );

   assign q_re_s[0] = '0;
   assign q_im_s[0] = '0;

   for (genvar i = 0; i < QB; i++) begin : g_cell
      cau_div_cell #(.WIDTH(WIDTH)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .ctl_i     (ctl_s[i]),
         .side_re_i (side_re_s[i]),
         .side_im_i (side_im_s[i]),
         .den_i     (den_s[i]),
         .rem_re_i  (rem_re_s[i]),
         .rem_im_i  (rem_im_s[i]),
         .nl_re_i   (nl_re_s[i]),
         .nl_im_i   (nl_im_s[i]),
         .q_re_i    (q_re_s[i]),
         .q_im_i    (q_im_s[i]),
         .ctl_o     (ctl_s[i+1]),
         .side_re_o (side_re_s[i+1]),
         .side_im_o (side_im_s[i+1]),
         .den_o     (den_s[i+1]),
         .rem_re_o  (rem_re_s[i+1]),
         .rem_im_o  (rem_im_s[i+1]),
         .nl_re_o   (nl_re_s[i+1]),
         .nl_im_o   (nl_im_s[i+1]),
         .q_re_o    (q_re_s[i+1]),
         .q_im_o    (q_im_s[i+1])
      );
   end

   // Output stage: sign and clamp the quotients, or pass the short results.
   cau_ctl_type      ctl_f;
   logic [QB-1:0]    q_re, q_im, nq_re, nq_im;
   logic [WIDTH-1:0] res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic             eq_ff, dz_ff, dz_in, sat_ff, sat_in;
   logic             sat_re, sat_im;

   always_comb begin
      ctl_f  = ctl_s[QB];
      q_re   = q_re_s[QB];
      q_im   = q_im_s[QB];
      nq_re  = -q_re;
      nq_im  = -q_im;
      sat_re = 1'b0;
      sat_im = 1'b0;
      dz_in  = ctl_f.dz;
      if (!ctl_f.is_div) begin
         res_re_in = side_re_s[QB];
         res_im_in = side_im_s[QB];
         sat_in    = ctl_f.sat;
      end else if (ctl_f.dz) begin
         res_re_in = '0;
         res_im_in = '0;
         sat_in    = 1'b0;
      end else begin
         if (ctl_f.neg_re) begin
            sat_re    = ctl_f.ovf_re || (q_re > MINQ);
            res_re_in = sat_re ? MINV : nq_re[WIDTH-1:0];
         end else begin
            sat_re    = ctl_f.ovf_re || (q_re > MAXQ);
            res_re_in = sat_re ? MAXV : q_re[WIDTH-1:0];
         end
         if (ctl_f.neg_im) begin
            sat_im    = ctl_f.ovf_im || (q_im > MINQ);
            res_im_in = sat_im ? MINV : nq_im[WIDTH-1:0];
         end else begin
            sat_im    = ctl_f.ovf_im || (q_im > MAXQ);
            res_im_in = sat_im ? MAXV : q_im[WIDTH-1:0];
         end
         sat_in = sat_re || sat_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= ctl_f.valid;
      end
      if (adv) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         eq_ff     <= ctl_f.eq;
         dz_ff     <= dz_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.res_re      = res_re_ff;
   assign rsp_if.res_im      = res_im_ff;
   assign rsp_if.is_equal    = eq_ff;
   assign rsp_if.div_by_zero = dz_ff;
   assign rsp_if.saturated   = sat_ff;

   // A divide by zero always gives a zero, unsaturated result.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && dz_ff |-> res_re_ff == '0 && res_im_ff == '0 && !sat_ff)
      else $error("divide by zero response is not zero");

   // Compare and arithmetic flags come from different commands.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(eq_ff && (dz_ff || sat_ff)))
      else $error("equality flag set together with an arithmetic flag");

   // Backpressure only comes from a response that is waiting.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> out_valid_ff && !rsp_if.ready)
      else $error("request side stalled without a waiting response");

   // A stalled pipeline keeps the request that is about to reach the output.
   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(ctl_s[QB]))
      else $error("divider chain moved during a stall");

endmodule

// ----- sv/cau_front.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Three pipeline stages: products, sums and the divider set-up, with the
// add, subtract, multiply and compare results finished on the way.
// ----------------------------------------------------------------------------
module cau_front #(
   parameter int WIDTH     = cau_pkg::CAU_WIDTH,
   parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           valid_i,
   input  logic [cau_pkg::CAU_CMD_W-1:0]  cmd_i,
   input  logic signed [WIDTH-1:0]        a_re_i,
   input  logic signed [WIDTH-1:0]        a_im_i,
   input  logic signed [WIDTH-1:0]        b_re_i,
   input  logic signed [WIDTH-1:0]        b_im_i,
   output cau_pkg::cau_ctl_type           ctl_o,
   output logic signed [WIDTH-1:0]        side_re_o,
   output logic signed [WIDTH-1:0]        side_im_o,
   output logic [2*WIDTH-1:0]             den_o,
   output logic [2*WIDTH-1:0]             rem_re_o,
   output logic [2*WIDTH-1:0]             rem_im_o,
   output logic [WIDTH:0]                 nl_re_o,
   output logic [WIDTH:0]                 nl_im_o
);
   import cau_pkg::*;

   localparam int AW = WIDTH + 1;
   localparam int PW = 2 * WIDTH;
   localparam int SW = 2 * WIDTH + 1;
   localparam int DW = 2 * WIDTH;
   localparam int NW = 2 * WIDTH + FRAC_BITS;
   localparam int QB = WIDTH + 1;
   localparam logic [SW-1:0]    RND  = (SW'(1) << FRAC_BITS) - SW'(1);
   localparam logic [WIDTH-1:0] MAXV = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};

   // Stage 0: products, add/subtract and the equality compare
   logic                  v0_ff;
   logic [CAU_CMD_W-1:0]  cmd0_ff;
   logic                  eq0_ff, eq0_in;
   logic signed [AW-1:0]  as_re0_ff, as_re0_in, as_im0_ff, as_im0_in;
   logic signed [PW-1:0]  prr_ff, pii_ff, pri_ff, pir_ff, brr_ff, bii_ff;

   always_comb begin
      eq0_in = (cmd_i == CMD_EQ) && (a_re_i == b_re_i) && (a_im_i == b_im_i);
      if (cmd_i == CMD_SUB) begin
         as_re0_in = AW'(a_re_i) - AW'(b_re_i);
         as_im0_in = AW'(a_im_i) - AW'(b_im_i);
      end else begin
         as_re0_in = AW'(a_re_i) + AW'(b_re_i);
         as_im0_in = AW'(a_im_i) + AW'(b_im_i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= valid_i;
      end
      if (adv) begin
         cmd0_ff   <= cmd_i;
         eq0_ff    <= eq0_in;
         as_re0_ff <= as_re0_in;
         as_im0_ff <= as_im0_in;
         prr_ff    <= PW'(a_re_i) * PW'(b_re_i);
         pii_ff    <= PW'(a_im_i) * PW'(b_im_i);
         pri_ff    <= PW'(a_re_i) * PW'(b_im_i);
         pir_ff    <= PW'(a_im_i) * PW'(b_re_i);
         brr_ff    <= PW'(b_re_i) * PW'(b_re_i);
         bii_ff    <= PW'(b_im_i) * PW'(b_im_i);
      end
   end

   // Stage 1: sums of products and the divisor's squared magnitude
   logic                  v1_ff;
   logic [CAU_CMD_W-1:0]  cmd1_ff;
   logic                  eq1_ff;
   logic signed [AW-1:0]  as_re1_ff, as_im1_ff;
   logic signed [SW-1:0]  mre_ff, mim_ff, dre_ff, dim_ff;
   logic [DW-1:0]         den1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
      if (adv) begin
         cmd1_ff   <= cmd0_ff;
         eq1_ff    <= eq0_ff;
         as_re1_ff <= as_re0_ff;
         as_im1_ff <= as_im0_ff;
         mre_ff    <= SW'(prr_ff) - SW'(pii_ff);
         mim_ff    <= SW'(pri_ff) + SW'(pir_ff);
         dre_ff    <= SW'(prr_ff) + SW'(pii_ff);
         dim_ff    <= SW'(pir_ff) - SW'(pri_ff);
         den1_ff   <= DW'(brr_ff) + DW'(bii_ff);
      end
   end

   // Stage 2: finish the short operations and set up the divider
   cau_ctl_type           ctl_ff, ctl_in;
   logic signed [WIDTH-1:0] side_re_ff, side_re_in, side_im_ff, side_im_in;
   logic [DW-1:0]         den_ff, rem_re_ff, rem_re_in, rem_im_ff, rem_im_in;
   logic [QB-1:0]         nl_re_ff, nl_re_in, nl_im_ff, nl_im_in;

   logic signed [SW-1:0]  msh_re, msh_im, mag_re, mag_im;
   logic [NW-1:0]         num_re, num_im, hi_re, hi_im;
   logic                  ok_mre, ok_mim, ok_are, ok_aim;

   always_comb begin
      // Truncate toward zero: bias negative values before the shift.
      msh_re = $signed(mre_ff + (mre_ff[SW-1] ? RND : '0)) >>> FRAC_BITS;
      msh_im = $signed(mim_ff + (mim_ff[SW-1] ? RND : '0)) >>> FRAC_BITS;
      ok_mre = (msh_re[SW-1:WIDTH-1] == '0) || (msh_re[SW-1:WIDTH-1] == '1);
      ok_mim = (msh_im[SW-1:WIDTH-1] == '0) || (msh_im[SW-1:WIDTH-1] == '1);
      ok_are = (as_re1_ff[AW-1:WIDTH-1] == '0) || (as_re1_ff[AW-1:WIDTH-1] == '1);
      ok_aim = (as_im1_ff[AW-1:WIDTH-1] == '0) || (as_im1_ff[AW-1:WIDTH-1] == '1);

      mag_re = dre_ff[SW-1] ? -dre_ff : dre_ff;
      mag_im = dim_ff[SW-1] ? -dim_ff : dim_ff;
      num_re = {mag_re[DW-1:0], {FRAC_BITS{1'b0}}};
      num_im = {mag_im[DW-1:0], {FRAC_BITS{1'b0}}};
      hi_re  = num_re >> QB;
      hi_im  = num_im >> QB;

      ctl_in        = '0;
      ctl_in.valid  = v1_ff;
      side_re_in    = '0;
      side_im_in    = '0;
      rem_re_in     = hi_re[DW-1:0];
      rem_im_in     = hi_im[DW-1:0];
      nl_re_in      = num_re[QB-1:0];
      nl_im_in      = num_im[QB-1:0];

      unique case (cmd1_ff) inside
         CMD_ADD, CMD_SUB: begin
            side_re_in = ok_are ? as_re1_ff[WIDTH-1:0] : (as_re1_ff[AW-1] ? MINV : MAXV);
            side_im_in = ok_aim ? as_im1_ff[WIDTH-1:0] : (as_im1_ff[AW-1] ? MINV : MAXV);
            ctl_in.sat = !ok_are || !ok_aim;
         end
         CMD_MUL: begin
            side_re_in = ok_mre ? msh_re[WIDTH-1:0] : (msh_re[SW-1] ? MINV : MAXV);
            side_im_in = ok_mim ? msh_im[WIDTH-1:0] : (msh_im[SW-1] ? MINV : MAXV);
            ctl_in.sat = !ok_mre || !ok_mim;
         end
         CMD_DIV: begin
            ctl_in.is_div = 1'b1;
            ctl_in.dz     = (den1_ff == '0);
            ctl_in.neg_re = dre_ff[SW-1];
            ctl_in.neg_im = dim_ff[SW-1];
            // Quotient would not fit in the cells' bits: clamp later.
            ctl_in.ovf_re = hi_re >= NW'(den1_ff);
            ctl_in.ovf_im = hi_im >= NW'(den1_ff);
         end
         CMD_EQ: begin
            ctl_in.eq = eq1_ff;
         end
         default: begin
            ctl_in.sat = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
      if (adv) begin
         side_re_ff <= side_re_in;
         side_im_ff <= side_im_in;
         den_ff     <= den1_ff;
         rem_re_ff  <= rem_re_in;
         rem_im_ff  <= rem_im_in;
         nl_re_ff   <= nl_re_in;
         nl_im_ff   <= nl_im_in;
      end
   end

   assign ctl_o     = ctl_ff;
   assign side_re_o = side_re_ff;
   assign side_im_o = side_im_ff;
   assign den_o     = den_ff;
   assign rem_re_o  = rem_re_ff;
   assign rem_im_o  = rem_im_ff;
   assign nl_re_o   = nl_re_ff;
   assign nl_im_o   = nl_im_ff;

endmodule

// ----- sv/cau_div_cell.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider cell
// One restoring division step for the real and imaginary lanes; produces one
// quotient bit per lane and hands everything on to the next cell.
// ----------------------------------------------------------------------------
module cau_div_cell #(
   parameter int WIDTH = cau_pkg::CAU_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  cau_pkg::cau_ctl_type  ctl_i,
   input  logic [WIDTH-1:0]      side_re_i,
   input  logic [WIDTH-1:0]      side_im_i,
   input  logic [2*WIDTH-1:0]    den_i,
   input  logic [2*WIDTH-1:0]    rem_re_i,
   input  logic [2*WIDTH-1:0]    rem_im_i,
   input  logic [WIDTH:0]        nl_re_i,
   input  logic [WIDTH:0]        nl_im_i,
   input  logic [WIDTH:0]        q_re_i,
   input  logic [WIDTH:0]        q_im_i,
   output cau_pkg::cau_ctl_type  ctl_o,
   output logic [WIDTH-1:0]      side_re_o,
   output logic [WIDTH-1:0]      side_im_o,
   output logic [2*WIDTH-1:0]    den_o,
   output logic [2*WIDTH-1:0]    rem_re_o,
   output logic [2*WIDTH-1:0]    rem_im_o,
   output logic [WIDTH:0]        nl_re_o,
   output logic [WIDTH:0]        nl_im_o,
   output logic [WIDTH:0]        q_re_o,
   output logic [WIDTH:0]        q_im_o
);
   import cau_pkg::*;

   localparam int DW = 2 * WIDTH;
   localparam int QB = WIDTH + 1;

   cau_ctl_type     ctl_ff;
   logic [WIDTH-1:0] side_re_ff, side_im_ff;
   logic [DW-1:0]   den_ff, rem_re_ff, rem_re_in, rem_im_ff, rem_im_in;
   logic [QB-1:0]   nl_re_ff, nl_im_ff, q_re_ff, q_re_in, q_im_ff, q_im_in;
   logic [DW:0]     t_re, t_im;
   logic            ge_re, ge_im;

   always_comb begin
      // Bring down the next numerator bit and try the subtraction.
      t_re      = {rem_re_i, nl_re_i[QB-1]};
      t_im      = {rem_im_i, nl_im_i[QB-1]};
      ge_re     = t_re >= {1'b0, den_i};
      ge_im     = t_im >= {1'b0, den_i};
      rem_re_in = ge_re ? DW'(t_re - {1'b0, den_i}) : t_re[DW-1:0];
      rem_im_in = ge_im ? DW'(t_im - {1'b0, den_i}) : t_im[DW-1:0];
      q_re_in   = {q_re_i[QB-2:0], ge_re};
      q_im_in   = {q_im_i[QB-2:0], ge_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_i;
      end
      if (adv) begin
         side_re_ff <= side_re_i;
         side_im_ff <= side_im_i;
         den_ff     <= den_i;
         rem_re_ff  <= rem_re_in;
         rem_im_ff  <= rem_im_in;
         nl_re_ff   <= nl_re_i << 1;
         nl_im_ff   <= nl_im_i << 1;
         q_re_ff    <= q_re_in;
         q_im_ff    <= q_im_in;
      end
   end

   assign ctl_o     = ctl_ff;
   assign side_re_o = side_re_ff;
   assign side_im_o = side_im_ff;
   assign den_o     = den_ff;
   assign rem_re_o  = rem_re_ff;
   assign rem_im_o  = rem_im_ff;
   assign nl_re_o   = nl_re_ff;
   assign nl_im_o   = nl_im_ff;
   assign q_re_o    = q_re_ff;
   assign q_im_o    = q_im_ff;

endmodule
